// ===== rtl/hidt_pkg.sv =====
// Package for the handle/identifier table: sizes, command and status codes,
// transaction structs and the controller command struct. No dependencies.
`default_nettype none

package hidt_pkg;

    localparam int CAPACITY   = 16;
    localparam int SLOT_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ID_BITS    = 32;
    localparam int VALUE_BITS = 32;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_GET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NULL      = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [ID_BITS-1:0]    id;
        logic [VALUE_BITS-1:0] value;
    } hidt_req_t;

    typedef struct packed {
        logic [ID_BITS-1:0]    result_id;
        logic [VALUE_BITS-1:0] result_value;
        logic [1:0]            status;
    } hidt_rsp_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } hidt_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/hidt_ctrl.sv =====
// Controller for the handle/identifier table: two-state sequencer and
// response valid flag. Depends on hidt_pkg.
`default_nettype none

module hidt_ctrl
    import hidt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output hidt_ctl_t      ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        req_stall      = (state_reg != S_IDLE);
        ctl.capture    = (state_reg == S_IDLE) && req_valid;
        ctl.commit     = (state_reg == S_EXEC) && (!out_valid_reg || !rsp_stall);
        state_next     = state_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ctl.commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/hidt_dp.sv =====
// Datapath for the handle/identifier table: slot storage, parallel lookup,
// lowest-slot select, identifier counter and response register.
// Depends on hidt_pkg.
`default_nettype none

module hidt_dp
    import hidt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire hidt_ctl_t ctl,
    input  wire hidt_req_t req,
    output hidt_rsp_t      rsp
);

    hidt_req_t             req_reg;
    hidt_rsp_t             rsp_reg;
    hidt_rsp_t             rsp_next;
    logic [CAPACITY-1:0]   valid_reg;
    logic [CAPACITY-1:0]   valid_next;
    logic [ID_BITS-1:0]    ident_mem [CAPACITY];
    logic [VALUE_BITS-1:0] payload_mem [CAPACITY];
    logic [ID_BITS-1:0]    next_ident_reg;
    logic [ID_BITS-1:0]    next_ident_next;

    logic [CAPACITY-1:0]   hit_vec;
    logic [CAPACITY-1:0]   free_vec;
    logic [CAPACITY-1:0]   hit_one;
    logic [CAPACITY-1:0]   free_one;
    logic [SLOT_BITS-1:0]  hit_idx;
    logic [SLOT_BITS-1:0]  free_idx;
    logic [VALUE_BITS-1:0] hit_payload;
    logic                  slot_we;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_vec[i]  = valid_reg[i] && (ident_mem[i] == req_reg.id);
            free_vec[i] = !valid_reg[i];
        end
        // isolate lowest set bit
        hit_one  = hit_vec & (~hit_vec + {{(CAPACITY-1){1'b0}}, 1'b1});
        free_one = free_vec & (~free_vec + {{(CAPACITY-1){1'b0}}, 1'b1});
        hit_idx     = '0;
        free_idx    = '0;
        hit_payload = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit_one[i])
            begin
                hit_idx     = hit_idx | SLOT_BITS'(i);
                hit_payload = hit_payload | payload_mem[i];
            end
            if (free_one[i])
            begin
                free_idx = free_idx | SLOT_BITS'(i);
            end
        end
    end

    always_comb
    begin
        valid_next      = valid_reg;
        next_ident_next = next_ident_reg;
        slot_we         = 1'b0;
        rsp_next.result_id    = '0;
        rsp_next.result_value = '0;
        rsp_next.status       = ST_NOT_FOUND;
        unique case (req_reg.cmd)
            CMD_ADD:
            begin
                if (req_reg.value == '0)
                begin
                    rsp_next.status = ST_NULL;
                end
                else if (free_vec == '0)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    slot_we              = 1'b1;
                    valid_next[free_idx] = 1'b1;
                    rsp_next.result_id   = next_ident_reg;
                    rsp_next.status      = ST_OK;
                    next_ident_next      = (next_ident_reg == '1)
                                         ? {{(ID_BITS-1){1'b0}}, 1'b1}
                                         : next_ident_reg + {{(ID_BITS-1){1'b0}}, 1'b1};
                end
            end
            CMD_GET, CMD_DEL:
            begin
                if (req_reg.id == '0)
                begin
                    rsp_next.status = ST_NULL;
                end
                else if (hit_vec != '0)
                begin
                    rsp_next.status = ST_OK;
                    if (req_reg.cmd == CMD_GET)
                    begin
                        rsp_next.result_value = hit_payload;
                    end
                    else
                    begin
                        valid_next[hit_idx] = 1'b0;
                    end
                end
            end
            default:
            begin
                rsp_next.status = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            next_ident_reg <= {{(ID_BITS-1){1'b0}}, 1'b1};
        end
        else if (ctl.commit)
        begin
            valid_reg      <= valid_next;
            next_ident_reg <= next_ident_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= req;
        end
        if (ctl.commit)
        begin
            rsp_reg <= rsp_next;
            if (slot_we)
            begin
                ident_mem[free_idx]   <= next_ident_reg;
                payload_mem[free_idx] <= req_reg.value;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/handle_id_table.sv =====
// Top level of the handle/identifier table: controller plus datapath.
// Depends on hidt_pkg, hidt_ctrl and hidt_dp.
//
// Each request transaction (add, get or delete) is handled in order: the
// request is registered, then the parallel compare across all 16 slots,
// lowest-slot select and table update load the response register. A new
// request is not taken until the previous one has committed; a response
// held by rsp_stall delays only the commit of the following request. Slot
// valid bits clear at reset, so no clearing pass is needed.
`default_nettype none

module handle_id_table
    import hidt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire hidt_req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output hidt_rsp_t      rsp
);

    hidt_ctl_t ctl;

    hidt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    hidt_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/hidt_checker.sv =====
// Port-level checks for handle_id_table, attached by bind.
// Depends on hidt_pkg.
`default_nettype none

module hidt_checker
    import hidt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    input  wire logic      req_stall,
    input  wire hidt_req_t req,
    input  wire logic      rsp_valid,
    input  wire logic      rsp_stall,
    input  wire hidt_rsp_t rsp
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one in progress");

    a_id_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_id != '0) |-> rsp.status == ST_OK
            && rsp.result_value == '0)
        else $error("identifier returned without ok status");

    a_value_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_value != '0) |-> rsp.status == ST_OK
            && rsp.result_id == '0)
        else $error("value returned without ok status");

endmodule

bind handle_id_table hidt_checker u_hidt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for handle_id_table: directed table then random
// transactions, each checked against its typed row or an in-bench predictor.
// Depends on rtl/hidt_pkg.sv and rtl/handle_id_table.sv.
`timescale 1ns / 100ps

module tb;
    import hidt_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int DIRECTED_ROWS = 15;
    localparam int RANDOM_PER_PHASE = 700;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        hidt_req_t  txn;
        logic [4:0] reps;
        logic       typed;
        hidt_rsp_t  want;
    } plan_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    hidt_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    hidt_rsp_t rsp;

    int        req_idle_pct = 0;
    int        rsp_idle_pct = 0;
    logic      long_hold = 1'b0;
    logic      hold_used = 1'b0;
    int        hold_left = 0;
    int        quiet_cycles = 0;
    int        mismatches = 0;

    logic                  slot_used [CAPACITY];
    logic [ID_BITS-1:0]    slot_handle [CAPACITY];
    logic [VALUE_BITS-1:0] slot_data [CAPACITY];
    logic [ID_BITS-1:0]    next_handle;
    hidt_rsp_t             pending_rsp [$];

    plan_row_t directed_plan [DIRECTED_ROWS] = '{
        '{'{CMD_ADD, 32'd0, 32'd0}, 5'd1, 1'b1, '{32'd0, 32'd0, ST_NULL}},
        '{'{CMD_ADD, 32'd0, 32'hFFFF_FFFF}, 5'd1, 1'b1, '{32'd1, 32'd0, ST_OK}},
        '{'{CMD_GET, 32'd1, 32'd0}, 5'd1, 1'b1, '{32'd0, 32'hFFFF_FFFF, ST_OK}},
        '{'{CMD_GET, 32'd0, 32'hFFFF_FFFF}, 5'd1, 1'b1, '{32'd0, 32'd0, ST_NULL}},
        '{'{CMD_DEL, 32'd0, 32'd0}, 5'd1, 1'b1, '{32'd0, 32'd0, ST_NULL}},
        '{'{CMD_GET, 32'hFFFF_FFFF, 32'd0}, 5'd1, 1'b1, '{32'd0, 32'd0, ST_NOT_FOUND}},
        '{'{CMD_UNUSED, 32'd1, 32'hFFFF_FFFF}, 5'd1, 1'b1,
          '{32'd0, 32'd0, ST_NOT_FOUND}},
        '{'{CMD_DEL, 32'd1, 32'hFFFF_FFFF}, 5'd1, 1'b1, '{32'd0, 32'd0, ST_OK}},
        '{'{CMD_GET, 32'd1, 32'd0}, 5'd1, 1'b1, '{32'd0, 32'd0, ST_NOT_FOUND}},
        '{'{CMD_ADD, 32'd0, 32'h8000_0000}, 5'd16, 1'b0, '0},
        '{'{CMD_ADD, 32'd0, 32'd1}, 5'd1, 1'b1, '{32'd0, 32'd0, ST_FULL}},
        '{'{CMD_GET, 32'd17, 32'd0}, 5'd1, 1'b1, '{32'd0, 32'h8000_0000, ST_OK}},
        '{'{CMD_DEL, 32'd9, 32'd0}, 5'd1, 1'b1, '{32'd0, 32'd0, ST_OK}},
        '{'{CMD_ADD, 32'd0, 32'd1}, 5'd1, 1'b1, '{32'd18, 32'd0, ST_OK}},
        '{'{CMD_GET, 32'd18, 32'd0}, 5'd1, 1'b1, '{32'd0, 32'd1, ST_OK}}
    };

    handle_id_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    initial
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_used[i] = 1'b0;
            slot_handle[i] = '0;
            slot_data[i] = '0;
        end
        next_handle = 1;
    end

    // Lowest matching slot wins on get/delete; add takes the lowest free slot.
    function automatic hidt_rsp_t handle_table_step(input hidt_req_t t);
        hidt_rsp_t r;
        int        hit;
        int        free_slot;
        r = '0;
        r.status = ST_NOT_FOUND;
        hit = -1;
        free_slot = -1;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!slot_used[i])
                free_slot = i;
            else if (t.id != 0 && slot_handle[i] == t.id)
                hit = i;
        end
        case (t.cmd)
            CMD_ADD:
            begin
                if (t.value == 0)
                    r.status = ST_NULL;
                else if (free_slot < 0)
                    r.status = ST_FULL;
                else
                begin
                    slot_used[free_slot] = 1'b1;
                    slot_handle[free_slot] = next_handle;
                    slot_data[free_slot] = t.value;
                    r.result_id = next_handle;
                    r.status = ST_OK;
                    next_handle = (next_handle == '1) ? 1 : next_handle + 1;
                end
            end
            CMD_GET, CMD_DEL:
            begin
                if (t.id == 0)
                    r.status = ST_NULL;
                else if (hit >= 0)
                begin
                    r.status = ST_OK;
                    if (t.cmd == CMD_GET)
                        r.result_value = slot_data[hit];
                    else
                        slot_used[hit] = 1'b0;
                end
            end
            default:
                r.status = ST_NOT_FOUND;
        endcase
        return r;
    endfunction

    task automatic send_txn(input hidt_req_t t, input logic typed, input hidt_rsp_t want);
        hidt_rsp_t predicted;
        if ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= t;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = handle_table_step(t);
        pending_rsp.push_back(typed ? want : predicted);
    endtask

    task automatic drain_responses;
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (long_hold && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
    end

    always @(posedge clk)
    begin : response_check
        hidt_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, got id %h value %h status %0d",
                         $time, rsp.result_id, rsp.result_value, rsp.status);
                mismatches++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("result_id", want.result_id, rsp.result_id);
                check_field("result_value", want.result_value, rsp.result_value);
                check_field("status", 32'(want.status), 32'(rsp.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        hidt_req_t t;
        int        roll;
        int        sel;
        int        k;
        int        add_pct;
        add_pct = 40;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        req_idle_pct = 10;
        rsp_idle_pct <= 65;
        for (int r = 0; r < DIRECTED_ROWS; r++)
            for (int n = 0; n < directed_plan[r].reps; n++)
                send_txn(directed_plan[r].txn, directed_plan[r].typed, directed_plan[r].want);
        drain_responses();

        for (int phase = 0; phase < 3; phase++)
        begin
            req_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 65 : 0;
            rsp_idle_pct <= (phase == 0) ? 65 : (phase == 1) ? 10 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n % 100 == 0)
                    add_pct = $urandom_range(60, 20);
                if (phase == 2 && n == 200)
                    long_hold <= 1'b1;
                t = '0;
                t.value = $urandom;
                t.id = $urandom;
                roll = $urandom_range(99);
                if (roll < add_pct)
                begin
                    t.cmd = CMD_ADD;
                    if ($urandom_range(29) == 0)
                        t.value = '0;
                end
                else if (roll < 97)
                begin
                    t.cmd = roll[0] ? CMD_GET : CMD_DEL;
                    sel = $urandom_range(19);
                    if (sel < 13)
                    begin
                        k = $urandom_range(CAPACITY - 1);
                        t.id = slot_used[k] ? slot_handle[k] : next_handle - $urandom_range(8, 1);
                    end
                    else if (sel < 17)
                        t.id = next_handle - $urandom_range(40, 0);
                    else if (sel == 19)
                        t.id = '0;
                end
                else
                    t.cmd = CMD_UNUSED;
                send_txn(t, 1'b0, '0);
            end
            drain_responses();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hidt_pkg.sv
rtl/hidt_ctrl.sv
rtl/hidt_dp.sv
rtl/handle_id_table.sv
rtl/hidt_checker.sv
sim/tb.sv
